// ===== design/ais_pkg.sv =====
// Shared constants and types for the ascending integer sorter.
package ais_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;

endpackage

// ===== design/ais_if.sv =====
// Valid/ready channel interfaces for sorter input and result beats.
interface ais_in_if;
  import ais_pkg::*;

  logic  valid;
  logic  ready;
  data_t value;
  logic  last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface ais_out_if;
  import ais_pkg::*;

  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  last_result;

  modport source (output valid, output sorted_value, output last_result, input ready);
  modport sink   (input valid, input sorted_value, input last_result, output ready);
endinterface

// ===== design/ais_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
module ais_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ===== design/ascending_integer_sorter_unit.sv =====
// Top level: loads a set, sorts it by bottom-up merge between two RAMs, streams it out.
//
//   channel  | dir | payload                          | end of set
//   ---------+-----+----------------------------------+-------------------
//   in_ch    | in  | value (s32)                      | last_item = 1
//   out_ch   | out | sorted_value (s32)               | last_result = 1
//
// Load takes one beat per cycle; beats past MAX_ITEMS are dropped.
// Sort: ceil(log2 n) passes, each a pass-start, then setup and merge per run pair or
// lone tail run; a last pass-start opens the emit. One compare/write per cycle.
// Emit: one beat per cycle from the RAM read port; out stalls hold the RAM index.
// in_ch is ready only while loading. Synchronous active-low reset empties the set.
module ascending_integer_sorter_unit (
  input logic      clk,
  input logic      rst_n,
  ais_in_if.sink   in_ch,
  ais_out_if.source out_ch
);
  import ais_pkg::*;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_PASS  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_MERGE = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  cnt_t       cnt_r, cnt_nxt;
  logic       sel_r, sel_nxt;       // 0: data in RAM A, 1: data in RAM B
  cnt_t       w_r, w_nxt;
  cnt_t       lo_r, lo_nxt;
  cnt_t       mid_r, mid_nxt;
  cnt_t       hi_r, hi_nxt;
  cnt_t       ia_r, ia_nxt;
  cnt_t       ib_r, ib_nxt;
  cnt_t       k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;
  data_t      out_value_r;
  logic       out_last_r;

  logic  out_load;
  logic  a_we, b_we;
  addr_t wr_addr, rd_addr0, rd_addr1;
  data_t wr_data;
  logic [DATA_W-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
  data_t src_d0, src_d1;
  logic  a_left, b_left, take_a;
  cnt_t  two_w, lo_w, lo_2w, mid_c, hi_c;

  ais_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_ram_a (
    .clk    (clk),
    .we     (a_we),
    .waddr  (wr_addr),
    .wdata  (wr_data),
    .raddr0 (rd_addr0),
    .raddr1 (rd_addr1),
    .rdata0 (a_rd0),
    .rdata1 (a_rd1)
  );

  ais_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_ram_b (
    .clk    (clk),
    .we     (b_we),
    .waddr  (wr_addr),
    .wdata  (wr_data),
    .raddr0 (rd_addr0),
    .raddr1 (rd_addr1),
    .rdata0 (b_rd0),
    .rdata1 (b_rd1)
  );

  assign src_d0 = sel_r ? data_t'(b_rd0) : data_t'(a_rd0);
  assign src_d1 = sel_r ? data_t'(b_rd1) : data_t'(a_rd1);

  // Heads of both runs come straight from the RAM read registers.
  assign a_left = (ia_r < mid_r);
  assign b_left = (ib_r < hi_r);
  assign take_a = a_left && (!b_left || (src_d0 <= src_d1));

  assign two_w = w_r << 1;
  assign lo_w  = lo_r + w_r;
  assign lo_2w = lo_r + two_w;
  assign mid_c = (lo_w > cnt_r) ? cnt_r : lo_w;
  assign hi_c  = (lo_2w > cnt_r) ? cnt_r : lo_2w;

  assign in_ch.ready      = (state_r == S_LOAD);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.sorted_value = out_value_r;
  assign out_ch.last_result  = out_last_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    w_nxt     = w_r;
    lo_nxt    = lo_r;
    mid_nxt   = mid_r;
    hi_nxt    = hi_r;
    ia_nxt    = ia_r;
    ib_nxt    = ib_r;
    k_nxt     = k_r;
    out_load  = 1'b0;
    a_we      = 1'b0;
    b_we      = 1'b0;
    wr_addr   = k_r[ADDR_W-1:0];
    wr_data   = take_a ? src_d0 : src_d1;
    rd_addr0  = ia_r[ADDR_W-1:0];
    rd_addr1  = ib_r[ADDR_W-1:0];

    case (state_r)
      S_LOAD: begin
        wr_addr = cnt_r[ADDR_W-1:0];
        wr_data = in_ch.value;
        if (in_ch.valid) begin
          if (cnt_r < CNT_W'(MAX_ITEMS)) begin
            a_we    = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (in_ch.last_item) begin
            w_nxt     = CNT_W'(1);
            sel_nxt   = 1'b0;
            state_nxt = S_PASS;
          end
        end
      end

      S_PASS: begin
        if (w_r < cnt_r) begin
          lo_nxt    = '0;
          state_nxt = S_SETUP;
        end else begin
          k_nxt     = '0;
          rd_addr0  = '0;
          state_nxt = S_EMIT;
        end
      end

      S_SETUP: begin
        rd_addr0  = lo_r[ADDR_W-1:0];
        rd_addr1  = mid_c[ADDR_W-1:0];
        mid_nxt   = mid_c;
        hi_nxt    = hi_c;
        ia_nxt    = lo_r;
        ib_nxt    = mid_c;
        k_nxt     = lo_r;
        state_nxt = S_MERGE;
      end

      S_MERGE: begin
        a_we = sel_r;
        b_we = !sel_r;
        if (take_a) begin
          ia_nxt = ia_r + CNT_W'(1);
        end else begin
          ib_nxt = ib_r + CNT_W'(1);
        end
        rd_addr0 = ia_nxt[ADDR_W-1:0];
        rd_addr1 = ib_nxt[ADDR_W-1:0];
        k_nxt    = k_r + CNT_W'(1);
        if (k_nxt == hi_r) begin
          lo_nxt = lo_2w;
          if (lo_2w < cnt_r) begin
            state_nxt = S_SETUP;
          end else begin
            w_nxt     = two_w;
            sel_nxt   = !sel_r;
            state_nxt = S_PASS;
          end
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load = 1'b1;
          k_nxt    = k_r + CNT_W'(1);
          if (k_nxt == cnt_r) begin
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end
        end
        rd_addr0 = k_nxt[ADDR_W-1:0];
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
    w_r   <= w_nxt;
    lo_r  <= lo_nxt;
    mid_r <= mid_nxt;
    hi_r  <= hi_nxt;
    ia_r  <= ia_nxt;
    ib_r  <= ib_nxt;
    k_r   <= k_nxt;
    if (out_load) begin
      out_value_r <= src_d0;
      out_last_r  <= (k_nxt == cnt_r);
    end
  end

endmodule
